// ----- rtl/dtd_pkg.sv -----
// dtd_pkg: shared types, constants and tables for the datetime difference block
// no dependencies; used by the interfaces and every module of the block
`timescale 1ns / 1ps
`default_nettype none

package dtd_pkg;

    // field widths
    localparam int YearW  = 12;
    localparam int MonthW = 4;
    localparam int DayW   = 5;
    localparam int HourW  = 5;
    localparam int MinW   = 6;
    localparam int DaysW  = 21;

    // day number arithmetic
    localparam int YearAdjW  = YearW + 1;          // year may drop to -1
    localparam int SumW      = 14;                 // year + offset, up to 8811
    localparam int ProdW     = 24;                 // 1461 * sum
    localparam int CentW     = 6;                  // century count, up to 40
    localparam int CentProdW = 25;                 // year * reciprocal of 100
    localparam int MtermW    = 9;                  // month term, up to 489
    localparam int JdW       = 23;                 // partial day number
    localparam int DiffW     = 25;                 // signed day difference

    localparam int YearOff    = 4716;
    localparam int YearMul    = 1461;              // days in four years
    localparam int CentMul    = 5243;              // ceil(2^19 / 100)
    localparam int CentShift  = 19;
    localparam int GregBase   = 2;
    localparam int MinPerHour = 60;
    localparam int HourPerDay = 24;
    localparam int LastShifted = 2;                // february, last month moved back

    // one input transfer
    typedef struct packed {
        logic [YearW-1:0]  later_year;
        logic [MonthW-1:0] later_month;
        logic [DayW-1:0]   later_day;
        logic [HourW-1:0]  later_hour;
        logic [MinW-1:0]   later_minute;
        logic [YearW-1:0]  earlier_year;
        logic [MonthW-1:0] earlier_month;
        logic [DayW-1:0]   earlier_day;
        logic [HourW-1:0]  earlier_hour;
        logic [MinW-1:0]   earlier_minute;
    } t_dtd_in;

    // one output transfer
    typedef struct packed {
        logic             status;
        logic [DaysW-1:0] elapsed_days;
        logic [HourW-1:0] elapsed_hours;
        logic [MinW-1:0]  elapsed_minutes;
    } t_dtd_out;

    // stage enables handed to the day number unit
    typedef struct packed {
        logic en2;
        logic en3;
    } t_jdn_ctl;

    // floor(30.6001 * (m + 1)) with january and february as months 13 and 14
    function automatic logic [MtermW-1:0] month_term(input logic [MonthW-1:0] m);
        logic [MtermW-1:0] v;
        unique case (m)
            4'd0:  v = 9'd397;
            4'd1:  v = 9'd428;
            4'd2:  v = 9'd459;
            4'd3:  v = 9'd122;
            4'd4:  v = 9'd153;
            4'd5:  v = 9'd183;
            4'd6:  v = 9'd214;
            4'd7:  v = 9'd244;
            4'd8:  v = 9'd275;
            4'd9:  v = 9'd306;
            4'd10: v = 9'd336;
            4'd11: v = 9'd367;
            4'd12: v = 9'd397;
            4'd13: v = 9'd428;
            4'd14: v = 9'd459;
            4'd15: v = 9'd489;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/dtd_if.sv -----
// dtd_in_if, dtd_out_if: valid/ready channels carrying the timestamp pair and the result
// depends on dtd_pkg for the payload types
`timescale 1ns / 1ps
`default_nettype none

interface dtd_in_if;
    logic             valid;
    logic             ready;
    dtd_pkg::t_dtd_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dtd_out_if;
    logic              valid;
    logic              ready;
    dtd_pkg::t_dtd_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/dtd_prep.sv -----
// dtd_prep: moves january and february to the year before and looks up the month term
// depends on dtd_pkg
`timescale 1ns / 1ps
`default_nettype none

module dtd_prep (
    input  wire logic        [dtd_pkg::YearW-1:0]    i_year,
    input  wire logic        [dtd_pkg::MonthW-1:0]   i_month,
    output logic signed      [dtd_pkg::YearAdjW-1:0] o_year_adj,
    output logic             [dtd_pkg::MtermW-1:0]   o_mterm
);
    import dtd_pkg::*;

    logic signed [YearAdjW-1:0] w_year_s;
    logic                       w_shift;

    // months up to february count as months 13 and 14 of the year before
    assign w_year_s   = $signed({1'b0, i_year});
    assign w_shift    = (i_month <= MonthW'(LastShifted));
    assign o_year_adj = w_shift ? (w_year_s - YearAdjW'(1)) : w_year_s;
    assign o_mterm    = month_term(i_month);

endmodule

`default_nettype wire

// ----- rtl/dtd_jdn.sv -----
// dtd_jdn: two register stages forming a partial julian day number (constant offset dropped)
// depends on dtd_pkg; stage enables come from the pipeline control in the top level
`timescale 1ns / 1ps
`default_nettype none

module dtd_jdn (
    input  wire logic                                 i_clk,
    input  wire dtd_pkg::t_jdn_ctl                    i_ctl,
    input  wire logic signed [dtd_pkg::YearAdjW-1:0]  i_year_adj,
    input  wire logic        [dtd_pkg::MtermW-1:0]    i_mterm,
    input  wire logic        [dtd_pkg::DayW-1:0]      i_day,
    output logic             [dtd_pkg::JdW-1:0]       o_jd
);
    import dtd_pkg::*;

    logic signed [SumW:0]        w_sum_s;
    logic [SumW-1:0]             w_sum;
    logic [YearW-1:0]            w_ypos;
    logic [CentProdW-1:0]        w_cprod;
    logic [ProdW-1:0]            n_prod;
    logic [CentW-1:0]            n_cent;

    logic [ProdW-1:0]            r_prod;
    logic [CentW-1:0]            r_cent;
    logic [MtermW-1:0]           r_mterm;
    logic [DayW-1:0]             r_day;
    logic [JdW-1:0]              r_jd;
    logic [JdW-1:0]              n_jd;

    // stage 2: year term and century count, one multiplier each
    assign w_sum_s = (SumW+1)'(i_year_adj) + (SumW+1)'(YearOff);
    assign w_sum   = w_sum_s[SumW-1:0];
    assign n_prod  = ProdW'(w_sum) * ProdW'(YearMul);
    // a year of -1 has century 0 under truncation toward zero
    assign w_ypos  = i_year_adj[YearAdjW-1] ? '0 : i_year_adj[YearW-1:0];
    assign w_cprod = CentProdW'(w_ypos) * CentProdW'(CentMul);
    assign n_cent  = CentW'(w_cprod >> CentShift);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_prod  <= n_prod;
            r_cent  <= n_cent;
            r_mterm <= i_mterm;
            r_day   <= i_day;
        end
    end

    // stage 3: sum of the terms with the gregorian correction
    assign n_jd = JdW'(r_prod[ProdW-1:2]) + JdW'(r_mterm) + JdW'(r_day)
                + JdW'(GregBase) + JdW'(r_cent[CentW-1:2]) - JdW'(r_cent);

    always_ff @(posedge i_clk) begin
        if (i_ctl.en3) begin
            r_jd <= n_jd;
        end
    end

    assign o_jd = r_jd;

endmodule

`default_nettype wire

// ----- rtl/datetime_difference.sv -----
// datetime_difference: elapsed days, hours and minutes between two timestamps
// depends on dtd_pkg, dtd_if, dtd_prep and dtd_jdn
//
//   channel   dir   payload                                  transfer when
//   i_in      in    t_dtd_in  (later and earlier stamp)      valid && ready
//   o_out     out   t_dtd_out (status, days, hours, minutes) valid && ready
//
// four register stages: stamp prep and compare, multiplies, day number sums,
// then the day difference into the output register.
// one transfer is taken every cycle unless a stall at the output backs up to stage 1.
// reset (i_rst_n low at a clock edge) clears all stage valid bits.
// a stall at the output holds the full stages; bubbles in front still fill.
`timescale 1ns / 1ps
`default_nettype none

module datetime_difference (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    dtd_in_if.sink     i_in,
    dtd_out_if.source  o_out
);
    import dtd_pkg::*;

    localparam int DiffSmallW = 8;

    // pipeline control
    logic     r_v1, r_v2, r_v3, r_vo;
    logic     w_en1, w_en2, w_en3, w_en4;
    t_jdn_ctl w_jctl;

    assign w_en4 = !r_vo || o_out.ready;
    assign w_en3 = !r_v3 || w_en4;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;
    assign i_in.ready   = w_en1;
    assign w_jctl.en2   = w_en2;
    assign w_jctl.en3   = w_en3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in.valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_vo <= r_v3;
        end
    end

    // stage 1: month shift, lexical compare, hour and minute differences
    logic signed [YearAdjW-1:0]   w_yl, w_ye;
    logic        [MtermW-1:0]     w_ml, w_me;
    logic                         n_lex;
    logic signed [DiffSmallW-1:0] n_dh, n_dm;

    dtd_prep u_prep_l (.i_year(i_in.data.later_year), .i_month(i_in.data.later_month),
                       .o_year_adj(w_yl), .o_mterm(w_ml));
    dtd_prep u_prep_e (.i_year(i_in.data.earlier_year), .i_month(i_in.data.earlier_month),
                       .o_year_adj(w_ye), .o_mterm(w_me));

    assign n_lex = {i_in.data.later_year, i_in.data.later_month, i_in.data.later_day,
                    i_in.data.later_hour, i_in.data.later_minute}
                 < {i_in.data.earlier_year, i_in.data.earlier_month, i_in.data.earlier_day,
                    i_in.data.earlier_hour, i_in.data.earlier_minute};
    assign n_dh = $signed(DiffSmallW'(i_in.data.later_hour))
                - $signed(DiffSmallW'(i_in.data.earlier_hour));
    assign n_dm = $signed(DiffSmallW'(i_in.data.later_minute))
                - $signed(DiffSmallW'(i_in.data.earlier_minute));

    logic signed [YearAdjW-1:0]   r1_yl, r1_ye;
    logic        [MtermW-1:0]     r1_ml, r1_me;
    logic        [DayW-1:0]       r1_dl, r1_de;
    logic                         r1_lex;
    logic signed [DiffSmallW-1:0] r1_dh, r1_dm;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r1_yl  <= w_yl;
            r1_ye  <= w_ye;
            r1_ml  <= w_ml;
            r1_me  <= w_me;
            r1_dl  <= i_in.data.later_day;
            r1_de  <= i_in.data.earlier_day;
            r1_lex <= n_lex;
            r1_dh  <= n_dh;
            r1_dm  <= n_dm;
        end
    end

    // stages 2 and 3 of the day numbers
    logic [JdW-1:0] w_jd_l, w_jd_e;

    dtd_jdn u_jdn_l (.i_clk(i_clk), .i_ctl(w_jctl), .i_year_adj(r1_yl),
                     .i_mterm(r1_ml), .i_day(r1_dl), .o_jd(w_jd_l));
    dtd_jdn u_jdn_e (.i_clk(i_clk), .i_ctl(w_jctl), .i_year_adj(r1_ye),
                     .i_mterm(r1_me), .i_day(r1_de), .o_jd(w_jd_e));

    // stage 2: minute borrow, floor split by 60
    logic signed [1:0]            n_k;
    logic        [MinW-1:0]       n_min;

    always_comb begin
        priority if (r1_dm < -DiffSmallW'(MinPerHour)) begin
            n_k   = -2'sd2;
            n_min = MinW'(r1_dm + DiffSmallW'(2 * MinPerHour));
        end else if (r1_dm < 0) begin
            n_k   = -2'sd1;
            n_min = MinW'(r1_dm + DiffSmallW'(MinPerHour));
        end else if (r1_dm >= DiffSmallW'(MinPerHour)) begin
            n_k   = 2'sd1;
            n_min = MinW'(r1_dm - DiffSmallW'(MinPerHour));
        end else begin
            n_k   = 2'sd0;
            n_min = MinW'(r1_dm);
        end
    end

    logic                         r2_lex;
    logic signed [DiffSmallW-1:0] r2_dh;
    logic signed [1:0]            r2_k;
    logic        [MinW-1:0]       r2_min;

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r2_lex <= r1_lex;
            r2_dh  <= r1_dh;
            r2_k   <= n_k;
            r2_min <= n_min;
        end
    end

    // stage 3: hour borrow, floor split by 24
    logic signed [DiffSmallW-1:0] w_h2;
    logic signed [1:0]            n_j;
    logic        [HourW-1:0]      n_hour;

    assign w_h2 = r2_dh + DiffSmallW'(r2_k);

    always_comb begin
        priority if (w_h2 < -DiffSmallW'(HourPerDay)) begin
            n_j    = -2'sd2;
            n_hour = HourW'(w_h2 + DiffSmallW'(2 * HourPerDay));
        end else if (w_h2 < 0) begin
            n_j    = -2'sd1;
            n_hour = HourW'(w_h2 + DiffSmallW'(HourPerDay));
        end else if (w_h2 >= DiffSmallW'(HourPerDay)) begin
            n_j    = 2'sd1;
            n_hour = HourW'(w_h2 - DiffSmallW'(HourPerDay));
        end else begin
            n_j    = 2'sd0;
            n_hour = HourW'(w_h2);
        end
    end

    logic                   r3_lex;
    logic [MinW-1:0]        r3_min;
    logic [HourW-1:0]       r3_hour;
    logic signed [1:0]      r3_j;

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r3_lex  <= r2_lex;
            r3_min  <= r2_min;
            r3_hour <= n_hour;
            r3_j    <= n_j;
        end
    end

    // stage 4: day difference, sign check, output register
    logic signed [DiffW-1:0] w_days;
    logic                    w_bad;
    t_dtd_out                n_out, r_out;

    assign w_days = $signed(DiffW'(w_jd_l)) - $signed(DiffW'(w_jd_e)) + DiffW'(r3_j);
    assign w_bad  = r3_lex || w_days[DiffW-1];

    always_comb begin
        n_out.status          = w_bad;
        n_out.elapsed_days    = w_bad ? '0 : w_days[DaysW-1:0];
        n_out.elapsed_hours   = w_bad ? '0 : r3_hour;
        n_out.elapsed_minutes = w_bad ? '0 : r3_min;
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_vo;
    assign o_out.data  = r_out;

`ifndef ASSERT_OFF
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vo && r_out.status) |-> (r_out.elapsed_days == '0 && r_out.elapsed_hours == '0
                                    && r_out.elapsed_minutes == '0))
        else $error("error result carries nonzero elapsed fields");

    a_split_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo |-> (r_out.elapsed_hours < HourW'(HourPerDay)
                  && r_out.elapsed_minutes < MinW'(MinPerHour)))
        else $error("hours or minutes out of range");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> r_v1)
        else $error("accepted transfer did not enter stage 1");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_vo && !o_out.ready) |=> r_v3)
        else $error("stage 3 item lost during output stall");
`endif

endmodule

`default_nettype wire
